[src/spr_pkg.sv]
// Shared widths, codes and divider handshake types for the segmented prime sieve.
package spr_pkg;

  localparam int LIMIT_W    = 24;
  localparam int SEG_IDX_W  = 8;
  localparam int SEG_CNT_W  = 9;
  localparam int ACTION_W   = 2;
  localparam int PRIME_W    = 13;
  localparam int VALUE_W    = 17;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_W      = 32;

  localparam int DEFAULT_SEGMENT_DEPTH = 65536;

  localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_NEXT  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_COUNT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_N       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [PRIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
    logic [PRIME_W-1:0] remainder;
  } div_rsp_t;

endpackage

[src/spr_ifs.sv]
// Request and response channel interfaces of the segmented prime sieve.
interface spr_req_if import spr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PRIME_W-1:0]  sieve_prime;

  modport source (output valid, action, sieve_prime, input ready);
  modport sink   (input valid, action, sieve_prime, output ready);
endinterface

interface spr_rsp_if import spr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  result_value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

[src/spr_ram.sv]
// Generic single-clock RAM, one write port, one registered read port.
module spr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/spr_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module spr_div import spr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic               busy;
  logic               done;
  logic [STEP_W-1:0]  steps;
  logic [DIV_W-1:0]   quo;
  logic [PRIME_W-1:0] rem;
  logic [PRIME_W-1:0] dvs;
  logic [PRIME_W:0]   trial;
  logic [PRIME_W:0]   diff;
  logic               fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
        quo   <= req.dividend;
        rem   <= '0;
        dvs   <= req.divisor;
      end else if (busy) begin
        quo   <= {quo[DIV_W-2:0], fits};
        rem   <= fits ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

[src/segmented_prime_sieve.sv]
// Segmented prime sieve engine: controller, bounds datapath and mark store.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+-------------------------------
//   req     | in  | valid/ready     | action, sieve_prime
//   rsp     | out | valid/ready     | result_value, status
//   cfg     | in  | cfg_we only     | cfg_index, cfg_data
//
// One transaction at a time; the mark store takes one entry per cycle and
// the serial divider one bit per cycle. start: three divisions, then a clear;
// mark: one division, then the multiples; next: scan to the hit; count: scan.
// Synchronous reset clears control state; the store holds garbage until start.
// A result waits in the output register; the next request is taken meanwhile.
module segmented_prime_sieve import spr_pkg::*; #(
  parameter int SEGMENT_DEPTH = DEFAULT_SEGMENT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  spr_req_if.sink               req,
  spr_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(SEGMENT_DEPTH);
  localparam int CW     = $clog2(SEGMENT_DEPTH + 1);
  localparam int SQ_W   = 2 * PRIME_W;
  localparam int PW     = ((CW > SQ_W) ? CW : SQ_W) + 1;
  localparam int PROD_W = DIV_W + 1;
  localparam int T_W    = LIMIT_W + 1;
  localparam int ROOT_W = LIMIT_W / 2;
  localparam int SUM_W  = LIMIT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_QDIV, S_QWAIT, S_LODIV, S_LOWAIT, S_HIDIV, S_HIWAIT, S_CLEAR,
    S_MDIV, S_MWAIT, S_MSETUP, S_MWRITE, S_SCAN, S_FIN
  } state_t;

  state_t state;

  logic [LIMIT_W-1:0]   limit_n;
  logic [SEG_IDX_W-1:0] seg_index;
  logic [SEG_CNT_W-1:0] seg_count;

  logic [ACTION_W-1:0]  act;
  logic [PRIME_W-1:0]   prime;
  logic [LIMIT_W-1:0]   q_reg;
  logic [DIV_W-1:0]     lo_q;
  logic [LIMIT_W-1:0]   seg_low;
  logic [CW-1:0]        seg_size;
  logic [AW-1:0]        cursor;
  logic [CW-1:0]        addr;
  logic [PW-1:0]        ptr;
  logic                 rd_valid;
  logic [AW-1:0]        rd_idx;
  logic [CW-1:0]        cnt;
  logic [SQ_W-1:0]      sq_reg;
  logic [PRIME_W-1:0]   rem_reg;
  logic [VALUE_W-1:0]   res_value;
  logic [STATUS_W-1:0]  res_status;
  logic                 rsp_valid;
  logic [VALUE_W-1:0]   rsp_value;
  logic [STATUS_W-1:0]  rsp_status;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [LIMIT_W-1:0]   n_c;
  logic [LIMIT_W-1:0]   nm1;
  logic [SEG_CNT_W-1:0] p_c;
  logic [SEG_CNT_W-1:0] mult_op;
  logic [PROD_W-1:0]    prod;
  logic [DIV_W-1:0]     size_diff;
  logic [CW-1:0]        size_clamped;
  logic [T_W-1:0]       t_val;
  logic [LIMIT_W-1:0]   t_sq;
  logic                 too_many;
  logic [SQ_W-1:0]      mk_first;
  logic                 addr_live;
  logic                 mk_go;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic                 mem_wdata;
  logic                 mem_re;
  logic                 mem_rdata;
  logic                 rd_hit;
  logic [SUM_W-1:0]     nxt_sum;
  logic [VALUE_W-1:0]   nxt_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_n   <= LIMIT_W'(2);
      seg_index <= '0;
      seg_count <= SEG_CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT_N:       limit_n   <= cfg_data[LIMIT_W-1:0];
        CFG_SEGMENT_INDEX: seg_index <= cfg_data[SEG_IDX_W-1:0];
        CFG_SEGMENT_COUNT: seg_count <= cfg_data[SEG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_c     = (limit_n < LIMIT_W'(2)) ? LIMIT_W'(2) : limit_n;
  assign nm1     = n_c - LIMIT_W'(1);
  assign p_c     = (seg_count == '0) ? SEG_CNT_W'(1) : seg_count;
  assign mult_op = (state == S_HIDIV) ? SEG_CNT_W'(seg_index) + SEG_CNT_W'(1)
                                      : SEG_CNT_W'(seg_index);
  assign prod    = PROD_W'(mult_op) * PROD_W'(nm1);

  always_comb begin
    div_req.start   = (state == S_QDIV) || (state == S_LODIV) ||
                      (state == S_HIDIV) || (state == S_MDIV);
    div_req.divisor = (state == S_MDIV) ? prime : PRIME_W'(p_c);
    case (state)
      S_QDIV:           div_req.dividend = DIV_W'(nm1);
      S_LODIV, S_HIDIV: div_req.dividend = prod[DIV_W-1:0];
      S_MDIV:           div_req.dividend = DIV_W'(seg_low);
      default:          div_req.dividend = '0;
    endcase
  end

  spr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // segment bounds and the too-many-segments test
  assign size_diff    = div_rsp.quotient - lo_q;
  assign size_clamped = (size_diff > DIV_W'(SEGMENT_DEPTH)) ? CW'(SEGMENT_DEPTH)
                                                            : size_diff[CW-1:0];
  assign t_val        = T_W'(q_reg) + T_W'(3);
  assign t_sq         = LIMIT_W'(t_val[ROOT_W-1:0]) * LIMIT_W'(t_val[ROOT_W-1:0]);
  assign too_many     = (t_val < T_W'(1 << ROOT_W)) && (t_sq <= n_c);

  // first multiple inside the segment
  always_comb begin
    if (sq_reg > SQ_W'(seg_low)) begin
      mk_first = sq_reg - SQ_W'(seg_low);
    end else if (rem_reg != '0) begin
      mk_first = SQ_W'(prime - rem_reg);
    end else begin
      mk_first = '0;
    end
  end

  assign addr_live = addr < seg_size;
  assign mk_go     = ptr < PW'(seg_size);
  assign mem_we    = ((state == S_CLEAR) && addr_live) || ((state == S_MWRITE) && mk_go);
  assign mem_waddr = (state == S_CLEAR) ? addr[AW-1:0] : ptr[AW-1:0];
  assign mem_wdata = (state == S_MWRITE);
  assign mem_re    = (state == S_SCAN) && addr_live;
  assign rd_hit    = rd_valid && !mem_rdata && (act == ACT_NEXT);
  assign nxt_sum   = SUM_W'(seg_low) + SUM_W'(rd_idx);
  assign nxt_value = (nxt_sum > SUM_W'(VALUE_MAX)) ? VALUE_MAX : nxt_sum[VALUE_W-1:0];

  spr_ram #(
    .WIDTH (1),
    .DEPTH (SEGMENT_DEPTH)
  ) u_mark_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rd_valid  <= 1'b0;
      seg_low   <= '0;
      seg_size  <= '0;
      cursor    <= '0;
    end else begin
      if (rsp.ready && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            act        <= req.action;
            prime      <= req.sieve_prime;
            rd_valid   <= 1'b0;
            cnt        <= '0;
            res_status <= ST_OK;
            res_value  <= VALUE_W'(seg_size);
            case (req.action)
              ACT_START: state <= S_QDIV;
              ACT_MARK:  state <= (req.sieve_prime < PRIME_W'(2)) ? S_FIN : S_MDIV;
              ACT_NEXT: begin
                addr  <= CW'(cursor) + CW'(1);
                state <= S_SCAN;
              end
              default: begin
                addr  <= '0;
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_QDIV: state <= S_QWAIT;
        S_QWAIT: begin
          if (div_rsp.done) begin
            q_reg <= div_rsp.quotient[LIMIT_W-1:0];
            state <= S_LODIV;
          end
        end
        S_LODIV: state <= S_LOWAIT;
        S_LOWAIT: begin
          if (div_rsp.done) begin
            lo_q  <= div_rsp.quotient;
            state <= S_HIDIV;
          end
        end
        S_HIDIV: state <= S_HIWAIT;
        S_HIWAIT: begin
          if (div_rsp.done) begin
            seg_low    <= lo_q[LIMIT_W-1:0] + LIMIT_W'(2);
            seg_size   <= size_clamped;
            res_value  <= VALUE_W'(size_clamped);
            res_status <= too_many ? ST_TOO_MANY : ST_OK;
            cursor     <= '0;
            addr       <= '0;
            state      <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (addr_live) begin
            addr <= addr + CW'(1);
          end else begin
            state <= S_FIN;
          end
        end
        S_MDIV: begin
          sq_reg <= SQ_W'(prime) * SQ_W'(prime);
          state  <= S_MWAIT;
        end
        S_MWAIT: begin
          if (div_rsp.done) begin
            rem_reg <= div_rsp.remainder;
            state   <= S_MSETUP;
          end
        end
        S_MSETUP: begin
          ptr   <= PW'(mk_first);
          state <= S_MWRITE;
        end
        S_MWRITE: begin
          if (mk_go) begin
            ptr <= ptr + PW'(prime);
          end else begin
            state <= S_FIN;
          end
        end
        S_SCAN: begin
          if (rd_hit) begin
            cursor    <= rd_idx;
            res_value <= nxt_value;
            rd_valid  <= 1'b0;
            state     <= S_FIN;
          end else begin
            rd_valid <= addr_live;
            rd_idx   <= addr[AW-1:0];
            if (addr_live) begin
              addr <= addr + CW'(1);
            end
            if (rd_valid && !mem_rdata) begin
              cnt <= cnt + CW'(1);
            end
            if (!rd_valid && !addr_live) begin
              res_value  <= (act == ACT_NEXT) ? '0 : VALUE_W'(cnt);
              res_status <= (act == ACT_NEXT) ? ST_EMPTY : ST_OK;
              state      <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_value  <= res_value;
            rsp_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.result_value = rsp_value;
  assign rsp.status       = rsp_status;

endmodule
